/* design/kvt_pkg.sv */
// shared constants, command and status codes, and types of the keyed record table
package kvt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int REMOVED_MAX = 127;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_DEL_KEY   = 3'd1;
  localparam logic [2:0] OP_DEL_SCORE = 3'd2;
  localparam logic [2:0] OP_UPDATE    = 3'd3;
  localparam logic [2:0] OP_LOOKUP    = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  typedef struct packed {
    logic signed [31:0] key;
    logic [15:0]        score;
  } entry_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] key;
    logic [15:0]        score;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] score_out;
    logic [6:0]  removed_count;
  } res_t;

endpackage

/* design/keyed_record_table.sv */
// top level of the keyed record table: request port, scan engine and result register
//
// a table of TABLE_ENTRIES records, each a signed 32-bit key and a Q8.8 score,
// with keys kept unique. commands arrive on the req channel (command,
// record_key, record_score) and each produces exactly one transaction on the
// rsp channel (status, score_out, removed_count), in order.
// every command walks the whole table through the one read port of the
// entry memory, one entry per cycle, and one command is in flight at a
// time: req_ready drops after acceptance and rises again once the result
// has moved into the output register.
// the output register frees the engine, so the next command can be taken
// while a result still waits; a stalled rsp_ready holds that result and
// then holds the engine once it has a second result ready.
// reset empties the table at once (valid bits and occupancy in flops) and
// clears both channels; the key and score memory is not cleared.
module keyed_record_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         command,
  input  logic signed [31:0] record_key,
  input  logic [15:0]        record_score,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [1:0]         status,
  output logic [15:0]        score_out,
  output logic [6:0]         removed_count
);
  import kvt_pkg::*;

  req_t req;
  res_t res;
  logic eng_idle;
  logic eng_valid;
  logic eng_ready;

  always_comb begin
    req.op    = command;
    req.key   = record_key;
    req.score = record_score;
  end

  assign req_ready = eng_idle;
  assign eng_ready = !rsp_valid || rsp_ready;

  kvt_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (req_valid && eng_idle),
    .req      (req),
    .idle     (eng_idle),
    .res_valid(eng_valid),
    .res_ready(eng_ready),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (eng_ready) begin
      rsp_valid <= eng_valid;
      if (eng_valid) begin
        status        <= res.status;
        score_out     <= res.score_out;
        removed_count <= res.removed_count;
      end
    end
  end

endmodule

/* design/kvt_ram.sv */
// simple dual-port ram with one write port and one registered read port
module kvt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/kvt_engine.sv */
// scan engine: walks every table entry once per command and does read-modify-write
module kvt_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  kvt_pkg::req_t req,
  output logic        idle,
  output logic        res_valid,
  input  logic        res_ready,
  output kvt_pkg::res_t res
);
  import kvt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]               state;
  req_t                     req_q;
  logic [CNT_W-1:0]         issue_idx;
  logic                     rd_pend;
  logic [IDX_W-1:0]         rd_idx;
  logic [TABLE_ENTRIES-1:0] valid_bits;
  logic [CNT_W-1:0]         occupancy;
  logic                     hit_found;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic [CNT_W-1:0]         del_count;
  logic [15:0]              score_q;
  res_t                     res_q;

  logic                     issue_act;
  logic [IDX_W-1:0]         rd_addr;
  logic [$bits(entry_t)-1:0] rdata;
  entry_t                   ent;
  logic                     ent_v;
  logic                     key_hit;
  logic                     score_hit;
  logic                     scan_end;
  logic                     is_full;
  logic                     do_insert;
  logic                     do_update;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  entry_t                   wdata;
  res_t                     res_next;
  logic [6:0]               removed_sat;

  always_comb begin
    issue_act = (state == S_SCAN) && (issue_idx != CNT_W'(TABLE_ENTRIES));
    rd_addr   = issue_idx[IDX_W-1:0];
    ent       = entry_t'(rdata);
    ent_v     = valid_bits[rd_idx];
    key_hit   = rd_pend && ent_v && (ent.key == req_q.key);
    score_hit = rd_pend && ent_v && (ent.score == req_q.score);
    scan_end  = (state == S_SCAN) && !issue_act && !rd_pend;
    is_full   = (occupancy == CNT_W'(TABLE_ENTRIES)) || !free_found;
    do_insert = scan_end && (req_q.op == OP_INSERT) && !hit_found && !is_full;
    do_update = key_hit && (req_q.op == OP_UPDATE);
    we        = do_insert || do_update;
    waddr     = do_insert ? free_idx : rd_idx;
    wdata.key   = req_q.key;
    wdata.score = req_q.score;
  end

  kvt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // removal count saturates at the width of the result field
  always_comb begin
    if (32'(del_count) > 32'(REMOVED_MAX)) begin
      removed_sat = 7'(REMOVED_MAX);
    end else begin
      removed_sat = 7'(del_count);
    end
  end

  always_comb begin
    res_next = '0;
    case (req_q.op)
      OP_INSERT: begin
        if (hit_found) begin
          res_next.status = ST_DUP;
        end else if (is_full) begin
          res_next.status = ST_FULL;
        end
      end
      OP_DEL_KEY, OP_DEL_SCORE: begin
        res_next.removed_count = removed_sat;
      end
      OP_UPDATE: begin
        if (!hit_found) begin
          res_next.status = ST_MISS;
        end
      end
      OP_LOOKUP: begin
        if (hit_found) begin
          res_next.score_out = score_q;
        end else begin
          res_next.status = ST_MISS;
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pend    <= 1'b0;
      valid_bits <= '0;
      occupancy  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            req_q      <= req;
            issue_idx  <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            free_idx   <= '0;
            del_count  <= '0;
            score_q    <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= issue_act;
          rd_idx  <= rd_addr;
          if (issue_act) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (rd_pend) begin
            // lowest free slot for an insert
            if (!ent_v && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            case (req_q.op)
              OP_INSERT, OP_UPDATE: begin
                if (key_hit) begin
                  hit_found <= 1'b1;
                end
              end
              OP_LOOKUP: begin
                if (key_hit) begin
                  hit_found <= 1'b1;
                  score_q   <= ent.score;
                end
              end
              OP_DEL_KEY: begin
                if (key_hit) begin
                  valid_bits[rd_idx] <= 1'b0;
                  del_count          <= del_count + 1'b1;
                end
              end
              OP_DEL_SCORE: begin
                if (score_hit) begin
                  valid_bits[rd_idx] <= 1'b0;
                  del_count          <= del_count + 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
          if (scan_end) begin
            res_q <= res_next;
            if (do_insert) begin
              valid_bits[free_idx] <= 1'b1;
              occupancy            <= occupancy + 1'b1;
            end else if (req_q.op == OP_DEL_KEY || req_q.op == OP_DEL_SCORE) begin
              occupancy <= occupancy - del_count;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_FIN);
  assign res       = res_q;

endmodule

/* design/kvt_checker.sv */
// port-level checks for the keyed record table, bound to the top level
module kvt_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic [2:0]         command,
  input logic signed [31:0] record_key,
  input logic [15:0]        record_score,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         status,
  input logic [15:0]        score_out,
  input logic [6:0]         removed_count
);
  import kvt_pkg::*;

  // a stalled result transaction holds its payload
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(score_out)
      && $stable(removed_count))
    else $error("rsp payload changed while stalled");

  // one command in flight: the port closes after an acceptance
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req accepted while a command is in flight");

  // a failing status carries no score and no removal count
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> score_out == 16'd0 && removed_count == 7'd0)
    else $error("error status with non-zero payload");

  // a delete that removes records reports an OK status and no score
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && removed_count != 7'd0 |-> status == ST_OK && score_out == 16'd0)
    else $error("removal count with unexpected status or score");

endmodule

bind keyed_record_table kvt_checker u_kvt_checker (.*);
